>>> src/hbw_pkg.sv
package hbw_pkg;

   localparam int PEER_IDX_W = 4;
   localparam int STATE_W    = 4;
   localparam int LIVES_W    = 4;
   localparam int INTERVAL_W = 16;
   localparam int TIME_W     = 32;
   localparam int MASK_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   typedef enum logic [0:0] {
      OP_HEARTBEAT = 1'b0,
      OP_TICK      = 1'b1
   } op_type;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_LIVES    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ERR_CODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IRQ_EN   = 2'd2;

   localparam logic [LIVES_W-1:0] LIVES_RST    = 4'd3;
   localparam logic [STATE_W-1:0] ERR_CODE_RST = 4'd15;
   localparam logic               IRQ_EN_RST   = 1'b1;

   typedef struct packed {
      logic [LIVES_W-1:0]    lives;
      logic [STATE_W-1:0]    state;
      logic [INTERVAL_W-1:0] interval;
      logic [TIME_W-1:0]     seen;
   } entry_type;

   typedef struct packed {
      logic err;
      logic dead;
   } upd_flag_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

>>> src/hbw_if.sv
interface hbw_req_if import hbw_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  operation;
   logic [PEER_IDX_W-1:0] peer_index;
   logic [STATE_W-1:0]    reported_state;
   logic [INTERVAL_W-1:0] interval_ticks;

   modport source (output valid, operation, peer_index, reported_state, interval_ticks,
                   input ready);
   modport sink   (input valid, operation, peer_index, reported_state, interval_ticks,
                   output ready);
endinterface

interface hbw_rsp_if import hbw_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [MASK_W-1:0]  interrupt_mask;
   logic [MASK_W-1:0]  error_mask;
   logic [MASK_W-1:0]  dead_mask;
   logic               peer_known;
   logic [STATE_W-1:0] peer_state;

   modport source (output valid, interrupt_mask, error_mask, dead_mask, peer_known, peer_state,
                   input ready);
   modport sink   (input valid, interrupt_mask, error_mask, dead_mask, peer_known, peer_state,
                   output ready);
endinterface

>>> src/heartbeat_lives_watchdog.sv
// heartbeat lives watchdog: tracks up to PEERS remote peers by number
// request channel (req_if): operation 0 is a heartbeat from peer_index carrying
//   reported_state and interval_ticks; operation 1 is one time tick
// response channel (rsp_if): one response per request with interrupt, error and
//   dead masks (nonzero only for ticks) and the indexed peer's known flag and state
// csr port: csr_we with csr_index/csr_wdata writes lives_on_refresh (0),
//   error_state_code (1) or interrupt_enable (2); other indexes are dropped
// sequence: a heartbeat is accepted in S_IDLE, written back in S_HB_WR and
//   handed to the response register from S_DONE; a tick sweeps all peers in
//   S_TICK before S_DONE; one request is in work at a time
// the tick sweep reads each peer entry from the table ram, updates it and writes
//   it back if valid, one entry per cycle, so the ram port pair sets the tick time
// the response sits in an output register; the next request is accepted while
//   it waits, and a finished request holds in its last step until the
//   response register is free
// reset: synchronous, clears all peer valid bits, the time counter and the control
//   flags, sets csr registers to defaults; the table ram needs no clearing pass
module heartbeat_lives_watchdog import hbw_pkg::*; #(
   parameter int PEERS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   hbw_req_if.sink               req_if,
   hbw_rsp_if.source             rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = (PEERS > 1) ? $clog2(PEERS) : 1;
   localparam int CMP_W = ((IDX_W > PEER_IDX_W) ? IDX_W : PEER_IDX_W) + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PEERS - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_HB_WR,
      S_TICK,
      S_DONE
   } state_type;

   // configuration registers
   logic [LIVES_W-1:0] lives_cfg_ff;
   logic [STATE_W-1:0] err_code_ff;
   logic               irq_en_ff;

   // control and datapath registers
   state_type             state_ff, state_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [PEERS-1:0]      valid_ff, valid_in;
   logic [PEER_IDX_W-1:0] idx_ff, idx_in;
   logic [STATE_W-1:0]    st_ff, st_in;
   logic [INTERVAL_W-1:0] ivl_ff, ivl_in;
   logic [IDX_W-1:0]      issue_idx_ff, issue_idx_in;
   logic                  issuing_ff, issuing_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic [IDX_W-1:0]      s1_idx_ff, s1_idx_in;
   logic [MASK_W-1:0]     err_acc_ff, err_acc_in;
   logic [MASK_W-1:0]     dead_acc_ff, dead_acc_in;
   logic [STATE_W-1:0]    q_state_ff, q_state_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]     rsp_irq_ff, rsp_irq_in;
   logic [MASK_W-1:0]     rsp_err_ff, rsp_err_in;
   logic [MASK_W-1:0]     rsp_dead_ff, rsp_dead_in;
   logic                  rsp_known_ff, rsp_known_in;
   logic [STATE_W-1:0]    rsp_state_ff, rsp_state_in;

   // table ram and update datapath
   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [IDX_W-1:0]   ram_raddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [ENTRY_W-1:0] ram_rdata;
   entry_type          rd_entry;
   entry_type          upd_entry;
   upd_flag_type       upd_flag;

   logic               idx_ok;
   logic [IDX_W-1:0]   hb_addr;
   logic               peer_valid;
   logic               s1_entry_valid;
   logic [MASK_W-1:0]  mask_bit;
   logic [LIVES_W-1:0] hb_lives;
   logic               load;

   hbw_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (PEERS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_entry = entry_type'(ram_rdata);

   hbw_upd u_upd (
      .entry_old   (rd_entry),
      .entry_valid (s1_entry_valid),
      .now_time    (now_ff),
      .err_code    (err_code_ff),
      .entry_new   (upd_entry),
      .flag        (upd_flag)
   );

   // indexed peer lookup; out of range indexes never write the table
   assign idx_ok         = CMP_W'(idx_ff) < CMP_W'(PEERS);
   assign hb_addr        = IDX_W'(idx_ff);
   assign peer_valid     = idx_ok && valid_ff[hb_addr];
   assign s1_entry_valid = valid_ff[s1_idx_ff];
   // peers beyond the mask width shift out and get no bit
   assign mask_bit       = MASK_W'(1) << s1_idx_ff;

   // heartbeat lives: a new peer always gets a refill, an error heartbeat keeps lives
   assign hb_lives = (!peer_valid || (st_ff != err_code_ff)) ? lives_cfg_ff : rd_entry.lives;

   always_comb begin
      state_in     = state_ff;
      now_in       = now_ff;
      valid_in     = valid_ff;
      idx_in       = idx_ff;
      st_in        = st_ff;
      ivl_in       = ivl_ff;
      issue_idx_in = issue_idx_ff;
      issuing_in   = issuing_ff;
      s1_valid_in  = 1'b0;
      s1_idx_in    = s1_idx_ff;
      err_acc_in   = err_acc_ff;
      dead_acc_in  = dead_acc_ff;
      q_state_in   = q_state_ff;
      ram_we       = 1'b0;
      ram_waddr    = s1_idx_ff;
      ram_wdata    = upd_entry;
      ram_raddr    = issue_idx_ff;
      req_if.ready = 1'b0;
      load         = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_if.ready = 1'b1;
            // heartbeat reads its entry right at acceptance
            ram_raddr    = IDX_W'(req_if.peer_index);
            if (req_if.valid) begin
               idx_in      = req_if.peer_index;
               st_in       = req_if.reported_state;
               ivl_in      = req_if.interval_ticks;
               err_acc_in  = '0;
               dead_acc_in = '0;
               q_state_in  = '0;
               if (op_type'(req_if.operation) == OP_TICK) begin
                  now_in       = now_ff + TIME_W'(1);
                  ram_raddr    = '0;
                  s1_valid_in  = 1'b1;
                  s1_idx_in    = '0;
                  issue_idx_in = IDX_W'(1);
                  issuing_in   = (PEERS > 1);
                  state_in     = S_TICK;
               end else begin
                  state_in = S_HB_WR;
               end
            end
         end
         S_HB_WR: begin
            if (idx_ok) begin
               ram_we            = 1'b1;
               ram_waddr         = hb_addr;
               ram_wdata         = {hb_lives, st_ff, ivl_ff, now_ff};
               valid_in[hb_addr] = 1'b1;
               q_state_in        = st_ff;
            end
            state_in = S_DONE;
         end
         S_TICK: begin
            // read side runs one entry ahead of the write side
            if (issuing_ff) begin
               ram_raddr    = issue_idx_ff;
               issue_idx_in = issue_idx_ff + IDX_W'(1);
               issuing_in   = (issue_idx_ff != LAST_IDX);
               s1_valid_in  = 1'b1;
               s1_idx_in    = issue_idx_ff;
            end
            if (s1_valid_ff) begin
               ram_we    = s1_entry_valid;
               ram_waddr = s1_idx_ff;
               ram_wdata = upd_entry;
               if (upd_flag.err) begin
                  err_acc_in = err_acc_ff | mask_bit;
               end
               if (upd_flag.dead) begin
                  dead_acc_in = dead_acc_ff | mask_bit;
               end
               // a tick never changes state, so grab the queried peer in passing
               if (CMP_W'(s1_idx_ff) == CMP_W'(idx_ff)) begin
                  q_state_in = rd_entry.state;
               end
               if (s1_idx_ff == LAST_IDX) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_irq_in   = rsp_irq_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_dead_in  = rsp_dead_ff;
      rsp_known_in = rsp_known_ff;
      rsp_state_in = rsp_state_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_irq_in   = irq_en_ff ? (err_acc_ff | dead_acc_ff) : '0;
         rsp_err_in   = err_acc_ff;
         rsp_dead_in  = dead_acc_ff;
         rsp_known_in = peer_valid;
         rsp_state_in = peer_valid ? q_state_ff : '0;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         now_ff       <= '0;
         valid_ff     <= '0;
         issuing_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         valid_ff     <= valid_in;
         issuing_ff   <= issuing_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      st_ff        <= st_in;
      ivl_ff       <= ivl_in;
      issue_idx_ff <= issue_idx_in;
      s1_idx_ff    <= s1_idx_in;
      err_acc_ff   <= err_acc_in;
      dead_acc_ff  <= dead_acc_in;
      q_state_ff   <= q_state_in;
      rsp_irq_ff   <= rsp_irq_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_dead_ff  <= rsp_dead_in;
      rsp_known_ff <= rsp_known_in;
      rsp_state_ff <= rsp_state_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lives_cfg_ff <= LIVES_RST;
         err_code_ff  <= ERR_CODE_RST;
         irq_en_ff    <= IRQ_EN_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LIVES:    lives_cfg_ff <= LIVES_W'(csr_wdata);
            CSR_ERR_CODE: err_code_ff  <= STATE_W'(csr_wdata);
            CSR_IRQ_EN:   irq_en_ff    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.interrupt_mask = rsp_irq_ff;
   assign rsp_if.error_mask     = rsp_err_ff;
   assign rsp_if.dead_mask      = rsp_dead_ff;
   assign rsp_if.peer_known     = rsp_known_ff;
   assign rsp_if.peer_state     = rsp_state_ff;

   // the table is only written by a heartbeat update or the tick sweep
   a_ram_we_phase: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_HB_WR || state_ff == S_TICK))
      else $error("table write outside an update step");

   // sweep never reads the entry it is writing back
   a_sweep_no_hazard: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TICK && issuing_ff && s1_valid_ff) |-> (issue_idx_ff != s1_idx_ff))
      else $error("sweep read and write collide on one entry");

   // sweep has drained before the response is loaded
   a_sweep_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> (!issuing_ff && !s1_valid_ff))
      else $error("sweep still active at completion");

   // a peer cleared for error is never also counted dead
   a_masks_disjoint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_err_ff & rsp_dead_ff) == '0))
      else $error("error and dead masks overlap");

   // interrupts only come from error or dead peers
   a_irq_subset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_irq_ff & ~(rsp_err_ff | rsp_dead_ff)) == '0))
      else $error("interrupt without cause");

endmodule

>>> src/hbw_ram.sv
module hbw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> src/hbw_upd.sv
module hbw_upd import hbw_pkg::*; (
   input  entry_type          entry_old,
   input  logic               entry_valid,
   input  logic [TIME_W-1:0]  now_time,
   input  logic [STATE_W-1:0] err_code,
   output entry_type          entry_new,
   output upd_flag_type       flag
);

   logic [TIME_W-1:0] elapsed;
   logic              alive;
   logic              err_hit;
   logic              late;

   // wrap-safe age of the peer's last heartbeat
   assign elapsed = now_time - entry_old.seen;
   assign alive   = entry_valid && (entry_old.lives != '0);
   assign err_hit = alive && (entry_old.state == err_code);
   assign late    = elapsed > TIME_W'(entry_old.interval);

   always_comb begin
      entry_new = entry_old;
      flag      = '0;
      if (err_hit) begin
         entry_new.lives = '0;
         flag.err        = 1'b1;
      end else if (alive && late) begin
         entry_new.lives = entry_old.lives - LIVES_W'(1);
         entry_new.seen  = now_time;
         flag.dead       = (entry_old.lives == LIVES_W'(1));
      end
   end

endmodule
